// ----- sv/smt_fts_pkg.sv -----
// Shared types, constants and helper functions for the SMT fetch thread selector.
package smt_fts_pkg;

  localparam int unsigned LANES   = 4;
  localparam int unsigned THREADS = 4;
  localparam int unsigned CNT_W   = 48;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;

  localparam logic [1:0] MODE_SHARED    = 2'd0;
  localparam logic [1:0] MODE_TIMESLICE = 2'd1;
  localparam logic [1:0] MODE_SOE       = 2'd2;

  localparam logic [IDX_W-1:0] REG_FETCH_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_THREADS_IN_USE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_QUANTUM_CYCLES  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SWITCH_PENALTY  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FAIRNESS_MARGIN = 3'd4;

  localparam logic [1:0]  RST_FETCH_MODE      = MODE_SHARED;
  localparam logic [2:0]  RST_THREADS_IN_USE  = 3'd4;
  localparam logic [31:0] RST_QUANTUM_CYCLES  = 32'd1000;
  localparam logic [7:0]  RST_SWITCH_PENALTY  = 8'd0;
  localparam logic [23:0] RST_FAIRNESS_MARGIN = 24'd100000;

  localparam int unsigned MAX_ACTIVE = (THREADS < LANES) ? THREADS : LANES;

  typedef struct packed {
    logic [3:0]       eligible_mask;
    logic [3:0]       long_latency_mask;
    logic [3:0]       running_mask;
    logic [CNT_W-1:0] committed_t0;
    logic [CNT_W-1:0] committed_t1;
    logic [CNT_W-1:0] committed_t2;
    logic [CNT_W-1:0] committed_t3;
  } fts_in_t;

  typedef struct packed {
    logic [3:0] fetch_grant_mask;
    logic [1:0] selected_thread;
    logic       switched;
    logic [7:0] stall_cycles;
  } fts_out_t;

  // Per-thread flags found by one lane
  typedef struct packed {
    logic elig;
    logic llat;
    logic run;
    logic unfair;
  } fts_lane_t;

  // Decision handed from the merge stage to the top level
  typedef struct packed {
    logic [3:0] grant;
    logic [1:0] ptr;
    logic       switched;
  } fts_dec_t;

  // Thread count taking part: zero acts as one, clamp to the lanes present
  function automatic logic [2:0] active_count(input logic [2:0] tiu);
    logic [2:0] n;
    n = tiu;
    if (n == 3'd0) n = 3'd1;
    if (n > 3'(MAX_ACTIVE)) n = 3'(MAX_ACTIVE);
    return n;
  endfunction

  // Pointer reduced modulo the thread count (count is 1..4)
  function automatic logic [1:0] ptr_mod(input logic [1:0] ptr, input logic [2:0] n);
    logic [1:0] r;
    unique case (n)
      3'd1:    r = 2'd0;
      3'd2:    r = {1'b0, ptr[0]};
      3'd3:    r = (ptr == 2'd3) ? 2'd0 : ptr;
      default: r = ptr;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/smt_fts_lane.sv -----
// One thread lane: gathers the thread's flags and checks its fairness lead.
module smt_fts_lane (
  input  logic                        elig_i,
  input  logic                        llat_i,
  input  logic                        run_i,
  input  logic [smt_fts_pkg::CNT_W-1:0] committed_i,
  input  logic [smt_fts_pkg::CNT_W:0]   cur_limit_i,
  output smt_fts_pkg::fts_lane_t      flags_o
);
  import smt_fts_pkg::*;

  always_comb begin
    flags_o.elig   = elig_i;
    flags_o.llat   = llat_i;
    flags_o.run    = run_i;
    // Candidate is unfair when its count leads the current thread's by more than the margin
    flags_o.unfair = {1'b0, committed_i} > cur_limit_i;
  end

endmodule

// ----- sv/smt_fts_merge.sv -----
// Merge stage: combines lane flags into the grant, the new pointer and the switch flag.
module smt_fts_merge (
  input  logic [1:0]                                mode_i,
  input  logic [2:0]                                n_i,
  input  logic [1:0]                                cur_i,
  input  logic                                      expired_i,
  input  smt_fts_pkg::fts_lane_t [smt_fts_pkg::LANES-1:0] lanes_i,
  output smt_fts_pkg::fts_dec_t                     dec_o
);
  import smt_fts_pkg::*;

  logic [2:0] limit;
  logic [2:0] cand;
  logic [1:0] sel;
  logic       found;
  logic       must;
  logic       trigger;
  logic       hit;
  logic [3:0] elig_act;

  always_comb begin
    for (int t = 0; t < LANES; t++) begin
      elig_act[t] = lanes_i[t].elig && (3'(t) < n_i);
    end
    must    = !lanes_i[cur_i].run;
    trigger = expired_i || lanes_i[cur_i].llat || must;
    limit   = (mode_i == MODE_TIMESLICE) ? n_i : (n_i - 3'd1);
    found   = 1'b0;
    sel     = cur_i;
    cand    = 3'd0;
    hit     = 1'b0;
    // Walk the candidates in round-robin order after the current thread
    for (int k = 1; k <= LANES; k++) begin
      cand = {1'b0, cur_i} + 3'(k);
      if (cand >= n_i) cand = cand - n_i;
      if (mode_i == MODE_TIMESLICE) begin
        hit = lanes_i[cand[1:0]].elig;
      end else begin
        hit = lanes_i[cand[1:0]].elig &&
              (must || (!lanes_i[cand[1:0]].unfair && !lanes_i[cand[1:0]].llat));
      end
      if (!found && (3'(k) <= limit) && hit) begin
        found = 1'b1;
        sel   = cand[1:0];
      end
    end

    dec_o = '0;
    unique case (mode_i)
      MODE_SHARED: begin
        dec_o.grant = elig_act;
        dec_o.ptr   = cur_i;
      end
      MODE_TIMESLICE: begin
        dec_o.ptr   = sel;
        dec_o.grant = found ? (4'b0001 << sel) : 4'b0000;
      end
      MODE_SOE: begin
        dec_o.switched = trigger && found;
        dec_o.ptr      = dec_o.switched ? sel : cur_i;
      end
      default: begin
        dec_o.ptr = cur_i;
      end
    endcase
  end

endmodule

// ----- sv/smt_fetch_thread_selector.sv -----
// Top level of the SMT fetch thread selector.
// The result of an input transfer is in the output register in the cycle after it.
// Throughput: one item per cycle while the output is not stalled; the pointer and switch-age update on each item.
// The output register lets a new item in while the held result is being taken.
// Reset clears pointer, switch age and output valid, and loads register defaults.
module smt_fetch_thread_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smt_fts_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [smt_fts_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  smt_fts_pkg::fts_in_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output smt_fts_pkg::fts_out_t            out_data_o
);
  import smt_fts_pkg::*;

  logic [1:0]  mode_q;
  logic [2:0]  tiu_q;
  logic [31:0] quantum_q;
  logic [7:0]  penalty_q;
  logic [23:0] margin_q;

  logic [1:0]  ptr_q, ptr_d;
  // Items accepted since the last switch, counting the switch item; restarts at one on a switch
  logic [63:0] elapsed_q, elapsed_d;
  logic        out_valid_q;
  fts_out_t    out_q, out_d;

  logic             accept;
  logic [2:0]       n;
  logic [1:0]       cur;
  logic             expired;
  logic [CNT_W-1:0] committed [LANES];
  logic [CNT_W:0]   cur_limit;
  fts_lane_t [LANES-1:0] lanes;
  fts_dec_t         dec;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign n   = active_count(tiu_q);
  assign cur = ptr_mod(ptr_q, n);
  assign expired = (|elapsed_q[63:32]) || (elapsed_q[31:0] > quantum_q);

  assign committed[0] = in_data_i.committed_t0;
  assign committed[1] = in_data_i.committed_t1;
  assign committed[2] = in_data_i.committed_t2;
  assign committed[3] = in_data_i.committed_t3;
  assign cur_limit = {1'b0, committed[cur]} + (CNT_W + 1)'(margin_q);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    smt_fts_lane u_lane (
      .elig_i      (in_data_i.eligible_mask[g]),
      .llat_i      (in_data_i.long_latency_mask[g]),
      .run_i       (in_data_i.running_mask[g]),
      .committed_i (committed[g]),
      .cur_limit_i (cur_limit),
      .flags_o     (lanes[g])
    );
  end

  smt_fts_merge u_merge (
    .mode_i    (mode_q),
    .n_i       (n),
    .cur_i     (cur),
    .expired_i (expired),
    .lanes_i   (lanes),
    .dec_o     (dec)
  );

  always_comb begin
    // Shared and unused modes leave the pointer exactly as it stands
    ptr_d     = ((mode_q == MODE_TIMESLICE) || (mode_q == MODE_SOE)) ? dec.ptr : ptr_q;
    elapsed_d = dec.switched ? 64'd1 : (elapsed_q + 64'd1);
    out_d.selected_thread = ptr_d;
    out_d.switched        = dec.switched;
    out_d.stall_cycles    = dec.switched ? penalty_q : 8'd0;
    // In SOE mode, grant the pointed thread if eligible, but drop the grant on a switch when a penalty applies
    if (mode_q == MODE_SOE) begin
      out_d.fetch_grant_mask =
        (in_data_i.eligible_mask[dec.ptr] && !(dec.switched && (penalty_q != 8'd0))) ?
        (4'b0001 << dec.ptr) : 4'b0000;
    end else begin
      out_d.fetch_grant_mask = dec.grant;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= RST_FETCH_MODE;
      tiu_q     <= RST_THREADS_IN_USE;
      quantum_q <= RST_QUANTUM_CYCLES;
      penalty_q <= RST_SWITCH_PENALTY;
      margin_q  <= RST_FAIRNESS_MARGIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FETCH_MODE:      mode_q    <= cfg_wdata_i[1:0];
        REG_THREADS_IN_USE:  tiu_q     <= cfg_wdata_i[2:0];
        REG_QUANTUM_CYCLES:  quantum_q <= cfg_wdata_i[31:0];
        REG_SWITCH_PENALTY:  penalty_q <= cfg_wdata_i[7:0];
        REG_FAIRNESS_MARGIN: margin_q  <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= 2'd0;
      elapsed_q   <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ptr_q       <= ptr_d;
        elapsed_q   <= elapsed_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  a_switch_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.switched) |-> $onehot0(out_q.fetch_grant_mask))
    else $error("grant not one-hot on a switch");

  a_switch_resets_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && dec.switched) |=> (elapsed_q == 64'd1))
    else $error("switch age not restarted");

  a_age_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !dec.switched) |=> (elapsed_q == $past(elapsed_q) + 64'd1))
    else $error("switch age did not advance");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty output register");

endmodule
